/* rtl/pimt_pkg.sv */
package pimt_pkg;

	localparam int PEER_SLOTS = 64;
	localparam int ID_SPACE   = 256;

	localparam int SW = $clog2(PEER_SLOTS);
	localparam int IW = $clog2(ID_SPACE);
	localparam int CW = $clog2(ID_SPACE + 1);

	typedef enum logic [1:0] {
		CMD_MAP      = 2'd0,
		CMD_UNMAP    = 2'd1,
		CMD_FIND_KEY = 2'd2,
		CMD_FIND_ID  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ID_RANGE   = 3'd1,
		ST_UNKNOWN_ID = 3'd2,
		ST_FULL       = 3'd3,
		ST_NO_KEY     = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t          cmd;
		logic [IW-1:0] id;
		logic          oor;
		logic [7:0]    vdev;
		logic [47:0]   mac;
	} qitem_t;

endpackage

/* rtl/pimt_req_if.sv */
interface pimt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] peer_id;
	logic [7:0]  vdev_id;
	logic [47:0] mac_addr;

	modport source(output valid, command, peer_id, vdev_id, mac_addr, input ready);
	modport sink(input valid, command, peer_id, vdev_id, mac_addr, output ready);
endinterface

/* rtl/pimt_rsp_if.sv */
interface pimt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  entry_index;
	logic [7:0]  entry_vdev;
	logic [47:0] entry_mac;
	logic        entry_created;
	logic        entry_removed;
	logic        id_taken_over;

	modport source(output valid, status, entry_index, entry_vdev, entry_mac,
		entry_created, entry_removed, id_taken_over, input ready);
	modport sink(input valid, status, entry_index, entry_vdev, entry_mac,
		entry_created, entry_removed, id_taken_over, output ready);
endinterface

/* rtl/peer_id_map_table_top.sv */
// Peer ID map table: commands enter on req, one result per command leaves on rsp in order.
// A two-entry queue takes commands while the engine works; the engine handles one
// command at a time: LOOK, OWN, then for map/unmap CNT1 and/or CNT2 (read-modify-write
// of the per-slot ID count memory), then OUT; lookups and rejected commands skip the CNT
// states. The result register is loaded in OUT. Key search is a parallel compare over
// all slots. The table is empty right after reset; no clearing pass is run.
module peer_id_map_table_top
	import pimt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pimt_req_if.sink    req,
	pimt_rsp_if.source  rsp
);

	logic   q_valid, q_ready;
	qitem_t q_item;

	pimt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready)
	);

	pimt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready),
		.rsp     (rsp)
	);

endmodule

/* rtl/pimt_front.sv */
module pimt_front
	import pimt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pimt_req_if.sink    req,
	output logic        q_valid,
	output qitem_t      q_item,
	input  logic        q_ready
);

	qitem_t     buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	qitem_t     cls;
	logic       push, pop;

	always_comb begin
		cls.cmd  = cmd_t'(req.command);
		cls.id   = req.peer_id[IW-1:0];
		cls.oor  = req.peer_id >= 16'(ID_SPACE);
		cls.vdev = req.vdev_id;
		cls.mac  = req.mac_addr;
	end

	assign req.ready = cnt_q != 2'd2;
	assign push      = req.valid && req.ready;
	assign q_valid   = cnt_q != 2'd0;
	assign pop       = q_valid && q_ready;
	assign q_item    = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* rtl/pimt_back.sv */
module pimt_back
	import pimt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  qitem_t      q_item,
	output logic        q_ready,
	pimt_rsp_if.source  rsp
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOOK = 6'b000010,
		S_OWN  = 6'b000100,
		S_CNT1 = 6'b001000,
		S_CNT2 = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t             state_q;
	qitem_t             item_q;

	logic [PEER_SLOTS-1:0] slot_valid_q;
	logic [7:0]            cam_vdev_q [PEER_SLOTS];
	logic [47:0]           cam_mac_q  [PEER_SLOTS];
	logic [ID_SPACE-1:0]   own_valid_q;

	logic [SW-1:0] own_mem [ID_SPACE];
	logic [CW-1:0] cnt_mem [PEER_SLOTS];
	logic [55:0]   kv_mem  [PEER_SLOTS];
	logic [SW-1:0] own_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [55:0]   kv_rd_q;

	logic          hit_q, free_q, own_v_q;
	logic [SW-1:0] hit_idx_q, free_idx_q, s_q, old_q;
	status_t       status_q;
	logic          created_q, removed_q, taken_q, use_key_q;

	logic          hit, fre;
	logic [SW-1:0] hit_idx, free_idx, sel;
	logic          map_go, own_same;
	logic          cnt_we;
	logic [SW-1:0] cnt_wa, cnt_ra;
	logic [CW-1:0] cnt_wd, cnt_dec;
	logic          load;

	always_comb begin
		hit      = 1'b0;
		fre      = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && cam_vdev_q[i] == item_q.vdev
				&& cam_mac_q[i] == item_q.mac) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (!slot_valid_q[i]) begin
				fre      = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign sel      = hit_q ? hit_idx_q : free_idx_q;
	assign own_same = own_v_q && own_rd_q == sel;
	assign map_go   = state_q == S_OWN && item_q.cmd == CMD_MAP && !item_q.oor
		&& (hit_q || free_q) && !own_same;
	assign cnt_dec  = cnt_rd_q - CW'(cnt_rd_q != '0);
	assign q_ready  = state_q == S_IDLE;
	assign load     = state_q == S_OUT && (!rsp.valid || rsp.ready);

	always_comb begin
		cnt_ra = s_q;
		if (state_q == S_OWN)
			cnt_ra = (item_q.cmd == CMD_MAP) ? (own_v_q ? own_rd_q : sel) : own_rd_q;
		cnt_we = 1'b0;
		cnt_wa = s_q;
		cnt_wd = cnt_dec;
		case (state_q)
			S_CNT1: begin
				cnt_we = 1'b1;
				if (item_q.cmd == CMD_MAP)
					cnt_wa = old_q;
			end
			S_CNT2: begin
				cnt_we = 1'b1;
				cnt_wd = created_q ? CW'(1) : cnt_rd_q + CW'(1);
			end
			default: cnt_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		own_rd_q <= own_mem[item_q.id];
		if (map_go)
			own_mem[item_q.id] <= sel;
	end

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[cnt_ra];
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OWN)
			kv_rd_q <= kv_mem[own_rd_q];
		if (map_go && !hit_q)
			kv_mem[sel] <= {item_q.vdev, item_q.mac};
	end

	always_ff @(posedge clk) begin
		if (map_go && !hit_q) begin
			cam_vdev_q[sel] <= item_q.vdev;
			cam_mac_q[sel]  <= item_q.mac;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid)
					item_q <= q_item;
				created_q <= 1'b0;
				removed_q <= 1'b0;
				taken_q   <= 1'b0;
			end
			S_LOOK: begin
				hit_q      <= hit;
				hit_idx_q  <= hit_idx;
				free_q     <= fre;
				free_idx_q <= free_idx;
				own_v_q    <= own_valid_q[item_q.id];
			end
			S_OWN: begin
				use_key_q <= 1'b1;
				status_q  <= ST_OK;
				if (item_q.cmd == CMD_FIND_KEY) begin
					s_q <= hit_idx_q;
					if (!hit_q)
						status_q <= ST_NO_KEY;
				end else if (item_q.oor) begin
					status_q <= ST_ID_RANGE;
				end else if (item_q.cmd == CMD_MAP) begin
					s_q       <= sel;
					old_q     <= own_rd_q;
					created_q <= !hit_q && free_q;
					taken_q   <= map_go && own_v_q;
					if (!hit_q && !free_q)
						status_q <= ST_FULL;
				end else begin
					use_key_q <= 1'b0;
					s_q       <= own_rd_q;
					if (!own_v_q)
						status_q <= ST_UNKNOWN_ID;
				end
			end
			S_CNT1: begin
				if (cnt_dec == '0)
					removed_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			own_valid_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) state_q <= S_LOOK;
				S_LOOK: state_q <= S_OWN;
				S_OWN: begin
					state_q <= S_OUT;
					if (map_go) begin
						slot_valid_q[sel]       <= 1'b1;
						own_valid_q[item_q.id]  <= 1'b1;
						state_q <= own_v_q ? S_CNT1 : S_CNT2;
					end else if (item_q.cmd == CMD_UNMAP && !item_q.oor && own_v_q) begin
						own_valid_q[item_q.id] <= 1'b0;
						state_q <= S_CNT1;
					end
				end
				S_CNT1: begin
					if (cnt_dec == '0)
						slot_valid_q[cnt_wa] <= 1'b0;
					state_q <= (item_q.cmd == CMD_MAP) ? S_CNT2 : S_OUT;
				end
				S_CNT2: state_q <= S_OUT;
				S_OUT: if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.valid <= 1'b0;
		else if (load)
			rsp.valid <= 1'b1;
		else if (rsp.ready)
			rsp.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp.status        <= status_q;
			rsp.entry_index   <= '0;
			rsp.entry_vdev    <= '0;
			rsp.entry_mac     <= '0;
			rsp.entry_created <= 1'b0;
			rsp.entry_removed <= 1'b0;
			rsp.id_taken_over <= 1'b0;
			if (status_q == ST_OK) begin
				rsp.entry_index   <= 6'(s_q);
				rsp.entry_vdev    <= use_key_q ? item_q.vdev : kv_rd_q[55:48];
				rsp.entry_mac     <= use_key_q ? item_q.mac : kv_rd_q[47:0];
				rsp.entry_created <= created_q;
				rsp.entry_removed <= removed_q;
				rsp.id_taken_over <= taken_q;
			end
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.entry_index == '0
		&& !rsp.entry_created && !rsp.entry_removed && !rsp.id_taken_over)
		else $error("error result carries entry data");

	a_created_valid: assert property (@(posedge clk) disable iff (!arst_n)
		map_go && !hit_q |=> slot_valid_q[s_q])
		else $error("created slot not marked valid");

	a_take_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.id_taken_over |-> rsp.status == ST_OK)
		else $error("takeover on failed command");

endmodule
